@@ hw/rtl/crcmw_pkg.sv @@
package crcmw_pkg;

  // Widths of the channel fields
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CRC_W   = 32;

  // Bytes taken from one word; larger counts saturate here
  localparam int unsigned BYTES_PER_WORD = 8;

  // Generator polynomial and reset values
  localparam logic [CRC_W-1:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified word handed from front to back
  typedef struct packed {
    logic [CRC_W-1:0]   data_crc;  // data contribution from a zero remainder
    logic [COUNT_W-1:0] nbytes;    // bytes to fold, 0..BYTES_PER_WORD
    logic               first;     // reload start value before folding
  } crcmw_entry_t;

  // Queue status seen by both neighbors
  typedef struct packed {
    logic empty;
    logic full;
  } crcmw_qstat_t;

  // Fold one byte into the remainder, MSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] rem,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] r;
    r = rem ^ {data, 24'h000000};
    for (int b = 0; b < 8; b++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Contribution of a full 8-byte word when starting from zero
  function automatic logic [CRC_W-1:0] crc_word_zero(input logic [DATA_W-1:0] data);
    logic [CRC_W-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r = crc_byte(r, data[8*k +: 8]);
    end
    return r;
  endfunction

  // Advance a remainder over n zero bytes
  function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] rem,
                                                   input logic [COUNT_W-1:0] n);
    logic [CRC_W-1:0] r;
    r = rem;
    for (int k = 0; k < 8; k++) begin
      if (COUNT_W'(k) < n) begin
        r = crc_byte(r, 8'h00);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/crcmw_in_if.sv @@
interface crcmw_in_if;
  logic                              valid;
  logic                              ready;
  logic [crcmw_pkg::DATA_W-1:0]      data_bytes;
  logic [crcmw_pkg::COUNT_W-1:0]     byte_count;
  logic                              first;

  modport source (output valid, output data_bytes, output byte_count, output first,
                  input ready);
  modport sink   (input valid, input data_bytes, input byte_count, input first,
                  output ready);
endinterface

@@ hw/rtl/crcmw_out_if.sv @@
interface crcmw_out_if;
  logic                         valid;
  logic                         ready;
  logic [crcmw_pkg::CRC_W-1:0]  crc;

  modport source (output valid, output crc, input ready);
  modport sink   (input valid, input crc, output ready);
endinterface

@@ hw/rtl/crc32_mpeg2_word_engine.sv @@
// Channel   Role   Payload                              Transfer
// in_ch     sink   data_bytes[63:0] byte_count[3:0] first  valid && ready
// out_ch    source crc[31:0]                            valid && ready
// config    write  start_value_wdata[31:0]              start_value_we
//
// One word per clock sustained while out_ch is ready; a word's CRC passes the front register
// (loaded at the transfer edge), then the queue, then the result register.
// The remainder feedback is a single XOR matrix over the remainder and the byte count.
// Reset (synchronous) sets start value and remainder to all ones and empties the queue.
// A stalled output fills the two-entry queue, then the front, then drops in_ch.ready.
module crc32_mpeg2_word_engine (
  input  logic                         clk,
  input  logic                         rst,
  crcmw_in_if.sink                     in_ch,
  crcmw_out_if.source                  out_ch,
  input  logic                         start_value_we,
  input  logic [crcmw_pkg::CRC_W-1:0]  start_value_wdata
);

  logic                    push;
  logic                    pop;
  crcmw_pkg::crcmw_entry_t push_entry;
  crcmw_pkg::crcmw_entry_t head;
  crcmw_pkg::crcmw_qstat_t q_stat;

  // Classify incoming words
  crcmw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple front and back
  crcmw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Fold words into the remainder
  crcmw_back u_back (
    .clk               (clk),
    .rst               (rst),
    .start_value_we    (start_value_we),
    .start_value_wdata (start_value_wdata),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_ch            (out_ch)
  );

`ifndef NO_ASSERTIONS
  // Queue cannot be both empty and full
  a_qstat_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full together");

  // A word taken from the queue always lands in the result register
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_ch.valid)
    else $error("popped word produced no result");

  // The front only hands over while the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // Input is refused only while the front holds a word the full queue cannot take
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> q_stat.full)
    else $error("input stalled with queue room");
`endif

endmodule

@@ hw/rtl/crcmw_front.sv @@
module crcmw_front (
  input  logic                   clk,
  input  logic                   rst,
  crcmw_in_if.sink               in_ch,
  input  crcmw_pkg::crcmw_qstat_t q_stat,
  output logic                   push,
  output crcmw_pkg::crcmw_entry_t push_entry
);

  logic                          busy;
  crcmw_pkg::crcmw_entry_t       entry;
  logic [crcmw_pkg::COUNT_W-1:0] nbytes;
  logic [6:0]                    pad_shift;
  logic [crcmw_pkg::DATA_W-1:0]  padded;
  logic                          take;

  // Saturate the byte count
  always_comb begin
    if (in_ch.byte_count > crcmw_pkg::COUNT_W'(crcmw_pkg::BYTES_PER_WORD)) begin
      nbytes = crcmw_pkg::COUNT_W'(crcmw_pkg::BYTES_PER_WORD);
    end else begin
      nbytes = in_ch.byte_count;
    end
  end

  // Lead with zero bytes so the valid bytes end the word; unused bytes fall off the top
  assign pad_shift = {4'(4'd8 - nbytes), 3'b000};
  assign padded    = in_ch.data_bytes << pad_shift;

  // Hand over when the queue has room
  assign push        = busy && !q_stat.full;
  assign push_entry  = entry;
  assign in_ch.ready = !busy || !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  // Hold the classified word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (push) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry.data_crc <= crcmw_pkg::crc_word_zero(padded);
      entry.nbytes   <= nbytes;
      entry.first    <= in_ch.first;
    end
  end

endmodule

@@ hw/rtl/crcmw_queue.sv @@
module crcmw_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  crcmw_pkg::crcmw_entry_t push_entry,
  input  logic                    pop,
  output crcmw_pkg::crcmw_entry_t head,
  output crcmw_pkg::crcmw_qstat_t q_stat
);

  crcmw_pkg::crcmw_entry_t      slots [crcmw_pkg::QUEUE_DEPTH];
  logic [crcmw_pkg::QPTR_W-1:0] wr_ptr;
  logic [crcmw_pkg::QPTR_W-1:0] rd_ptr;
  logic [crcmw_pkg::QCNT_W-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == crcmw_pkg::QCNT_W'(crcmw_pkg::QUEUE_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  function automatic logic [crcmw_pkg::QPTR_W-1:0] wrap_inc(
      input logic [crcmw_pkg::QPTR_W-1:0] p);
    if (p == crcmw_pkg::QPTR_W'(crcmw_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/crcmw_back.sv @@
module crcmw_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start_value_we,
  input  logic [crcmw_pkg::CRC_W-1:0]  start_value_wdata,
  input  crcmw_pkg::crcmw_entry_t      head,
  input  crcmw_pkg::crcmw_qstat_t      q_stat,
  output logic                         pop,
  crcmw_out_if.source                  out_ch
);

  logic [crcmw_pkg::CRC_W-1:0] start_value;
  logic [crcmw_pkg::CRC_W-1:0] remainder;
  logic [crcmw_pkg::CRC_W-1:0] base;
  logic [crcmw_pkg::CRC_W-1:0] remainder_next;
  logic                        valid;
  logic [crcmw_pkg::CRC_W-1:0] crc;

  // Take the next word when the result register is free or being drained
  assign pop = !q_stat.empty && (!valid || out_ch.ready);

  // Fold the word: advance the remainder over its bytes, add the data part
  assign base           = head.first ? start_value : remainder;
  assign remainder_next = crcmw_pkg::crc_advance(base, head.nbytes) ^ head.data_crc;

  assign out_ch.valid = valid;
  assign out_ch.crc   = crc;

  // Hold the start value register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= crcmw_pkg::CRC_ALL_ONES;
    end else if (start_value_we) begin
      start_value <= start_value_wdata;
    end
  end

  // Advance the running remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= crcmw_pkg::CRC_ALL_ONES;
      valid     <= 1'b0;
    end else begin
      if (pop) begin
        remainder <= remainder_next;
        valid     <= 1'b1;
      end else if (out_ch.ready) begin
        valid <= 1'b0;
      end
    end
  end

  // Hold the result until transfer
  always_ff @(posedge clk) begin
    if (pop) begin
      crc <= remainder_next;
    end
  end

endmodule
